// File: rtl/hlc_pkg.sv
// Shared types and constants for the Hamming leader clustering unit.
// No dependencies; used by hlc_distance and hamming_leader_clustering_unit.
`default_nettype none

package hlc_pkg;

   localparam int PointW = 32;
   localparam int ThrW = 6;
   localparam int IdW = 8;
   localparam int IndexW = 32;
   localparam int DistW = 6;

   localparam logic [ThrW-1:0] ThrReset = 6'd4;

   typedef logic [ThrW-1:0] thr_type;
   typedef logic [DistW-1:0] dist_type;

   typedef struct packed {
      dist_type distance;
      logic hit;
   } cmp_result_type;

endpackage

`default_nettype wire

// File: rtl/hlc_distance.sv
// Hamming distance between a point and one anchor, compared with the threshold.
// Depends on hlc_pkg.
`default_nettype none

module hlc_distance #(
   parameter int WIDTH = 32
) (
   input  wire logic [WIDTH-1:0] point,
   input  wire logic [WIDTH-1:0] anchor,
   input  wire hlc_pkg::thr_type threshold,
   output hlc_pkg::cmp_result_type result
);

   logic [hlc_pkg::PointW-1:0] diff;
   logic [2:0] nib_count [hlc_pkg::PointW/4];
   hlc_pkg::dist_type sum;

   function automatic logic [2:0] nib_pop(input logic [3:0] v);
      nib_pop = 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
   endfunction

   assign diff = hlc_pkg::PointW'(point ^ anchor);

   // Count each nibble on its own, then add the eight small counts.
   always_comb begin
      for (int i = 0; i < hlc_pkg::PointW/4; i++) begin
         nib_count[i] = nib_pop(diff[4*i +: 4]);
      end
   end

   always_comb begin
      sum = '0;
      for (int i = 0; i < hlc_pkg::PointW/4; i++) begin
         sum = sum + hlc_pkg::DistW'(nib_count[i]);
      end
   end

   assign result.distance = sum;
   assign result.hit = (sum < threshold);

endmodule

`default_nettype wire

// File: rtl/hamming_leader_clustering_unit.sv
// Hamming leader clustering unit: anchor memory, scan sequencer and result register.
// Depends on hlc_pkg and hlc_distance.
// A point is compared with the stored anchors in order, from anchor 0, until one claims it
// or all of them miss; the result is registered and the unit then returns to idle.
// The next point is taken in the cycle of the previous result, so points are handled one
// at a time; the scan reads one anchor per cycle.
// Results cannot be stalled. Reset empties the anchor table, zeroes the point counter
// and sets the threshold to 4; the memory itself is not swept.
`default_nettype none

module hamming_leader_clustering_unit #(
   parameter int VECTOR_WIDTH = 32,
   parameter int MAX_ANCHORS = 256
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic [hlc_pkg::PointW-1:0] req_point_bits,
   input  wire logic csr_wr_en,
   input  wire logic [hlc_pkg::ThrW-1:0] csr_wr_data,
   output logic rsp_valid,
   output logic [hlc_pkg::IdW-1:0] rsp_cluster_id,
   output logic rsp_new_cluster,
   output logic rsp_table_full,
   output logic [hlc_pkg::IndexW-1:0] rsp_point_index
);

   localparam int StoreW = (VECTOR_WIDTH < hlc_pkg::PointW) ? VECTOR_WIDTH : hlc_pkg::PointW;
   localparam int AW = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
   localparam int CW = $clog2(MAX_ANCHORS + 1);
   localparam logic [CW-1:0] MaxCount = CW'(MAX_ANCHORS);

   localparam logic StIdle = 1'b0;
   localparam logic StScan = 1'b1;

   logic state_ff, state_in;
   hlc_pkg::thr_type threshold_ff, threshold_in;
   logic [CW-1:0] anchor_count_ff, anchor_count_in;
   logic [hlc_pkg::IndexW-1:0] point_counter_ff, point_counter_in;
   logic [StoreW-1:0] point_ff, point_in;
   logic [CW-1:0] issue_idx_ff, issue_idx_in;
   logic [AW-1:0] cmp_idx_ff, cmp_idx_in;
   logic cmp_vld_ff, cmp_vld_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [hlc_pkg::IdW-1:0] rsp_id_ff, rsp_id_in;
   logic rsp_new_ff, rsp_new_in;
   logic rsp_full_ff, rsp_full_in;
   logic [hlc_pkg::IndexW-1:0] rsp_index_ff, rsp_index_in;

   logic [StoreW-1:0] anchor_mem [MAX_ANCHORS];
   logic [StoreW-1:0] rd_data_ff;
   logic rd_en;
   logic [AW-1:0] rd_addr;
   logic wr_en;

   hlc_pkg::cmp_result_type cmp;

   hlc_distance #(
      .WIDTH(StoreW)
   ) u_distance (
      .point(point_ff),
      .anchor(rd_data_ff),
      .threshold(threshold_ff),
      .result(cmp)
   );

   assign busy = (state_ff == StScan);

   always_comb begin
      state_in = state_ff;
      threshold_in = csr_wr_en ? csr_wr_data : threshold_ff;
      anchor_count_in = anchor_count_ff;
      point_counter_in = point_counter_ff;
      point_in = point_ff;
      issue_idx_in = issue_idx_ff;
      cmp_idx_in = cmp_idx_ff;
      cmp_vld_in = cmp_vld_ff;
      rsp_valid_in = 1'b0;
      rsp_id_in = rsp_id_ff;
      rsp_new_in = rsp_new_ff;
      rsp_full_in = rsp_full_ff;
      rsp_index_in = rsp_index_ff;
      rd_en = 1'b0;
      rd_addr = '0;
      wr_en = 1'b0;
      case (state_ff)
         StIdle: begin
            if (start) begin
               state_in = StScan;
               point_in = req_point_bits[StoreW-1:0];
               cmp_idx_in = '0;
               issue_idx_in = CW'(1);
               cmp_vld_in = (anchor_count_ff != '0);
               rd_en = (anchor_count_ff != '0);
            end
         end
         StScan: begin
            if (cmp_vld_ff) begin
               if (cmp.hit) begin
                  state_in = StIdle;
                  rsp_valid_in = 1'b1;
                  rsp_id_in = hlc_pkg::IdW'(cmp_idx_ff);
                  rsp_new_in = 1'b0;
                  rsp_full_in = 1'b0;
               end else begin
                  cmp_idx_in = cmp_idx_ff + AW'(1);
                  if (issue_idx_ff < anchor_count_ff) begin
                     rd_en = 1'b1;
                     rd_addr = issue_idx_ff[AW-1:0];
                     issue_idx_in = issue_idx_ff + CW'(1);
                  end else begin
                     cmp_vld_in = 1'b0;
                  end
               end
            end else begin
               // Every stored anchor missed: add the point, or report a full table.
               state_in = StIdle;
               rsp_valid_in = 1'b1;
               if (anchor_count_ff < MaxCount) begin
                  wr_en = 1'b1;
                  anchor_count_in = anchor_count_ff + CW'(1);
                  rsp_id_in = hlc_pkg::IdW'(anchor_count_ff);
                  rsp_new_in = 1'b1;
                  rsp_full_in = 1'b0;
               end else begin
                  rsp_id_in = '0;
                  rsp_new_in = 1'b0;
                  rsp_full_in = 1'b1;
               end
            end
            if (rsp_valid_in) begin
               rsp_index_in = point_counter_ff;
               point_counter_in = point_counter_ff + hlc_pkg::IndexW'(1);
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         threshold_ff <= hlc_pkg::ThrReset;
         anchor_count_ff <= '0;
         point_counter_ff <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         threshold_ff <= threshold_in;
         anchor_count_ff <= anchor_count_in;
         point_counter_ff <= point_counter_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      point_ff <= point_in;
      issue_idx_ff <= issue_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      rsp_id_ff <= rsp_id_in;
      rsp_new_ff <= rsp_new_in;
      rsp_full_ff <= rsp_full_in;
      rsp_index_ff <= rsp_index_in;
   end

   // Reads and writes never fall in the same cycle: a write ends the scan.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         anchor_mem[anchor_count_ff[AW-1:0]] <= point_ff;
      end
      if (rd_en) begin
         rd_data_ff <= anchor_mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cluster_id = rsp_id_ff;
   assign rsp_new_cluster = rsp_new_ff;
   assign rsp_table_full = rsp_full_ff;
   assign rsp_point_index = rsp_index_ff;

   a_new_xor_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_new_ff && rsp_full_ff))
      else $error("new cluster and full table reported together");

   a_new_grows_table: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_new_ff) |-> (anchor_count_ff == $past(anchor_count_ff) + CW'(1)))
      else $error("new cluster without anchor count increment");

   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_full_ff) |-> (anchor_count_ff == MaxCount))
      else $error("table full reported with free anchor slots");

   a_rsp_after_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == StIdle))
      else $error("result strobe while still scanning");

endmodule

`default_nettype wire

// File: dv/tb_hamming_leader_clustering_unit.sv
// Self-checking testbench for hamming_leader_clustering_unit: directed and random points,
// threshold changes while idle, table fill and overflow. Depends on hlc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_hamming_leader_clustering_unit;

   localparam int VectorW = 32;
   localparam int MaxAnchors = 256;
   localparam int TailCycles = MaxAnchors + 40;

   typedef enum int {OP_POINT, OP_THRESH, OP_DRAIN} op_kind_type;

   typedef struct {
      op_kind_type kind;
      logic [hlc_pkg::PointW-1:0] value;
   } pending_op_type;

   typedef struct packed {
      logic [hlc_pkg::IdW-1:0] cluster_id;
      logic new_cluster;
      logic table_full;
      logic [hlc_pkg::IndexW-1:0] point_index;
   } cluster_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [hlc_pkg::PointW-1:0] req_point_bits = '0;
   logic csr_wr_en = 1'b0;
   logic [hlc_pkg::ThrW-1:0] csr_wr_data = '0;
   logic rsp_valid;
   logic [hlc_pkg::IdW-1:0] rsp_cluster_id;
   logic rsp_new_cluster;
   logic rsp_table_full;
   logic [hlc_pkg::IndexW-1:0] rsp_point_index;

   hamming_leader_clustering_unit #(
      .VECTOR_WIDTH(VectorW),
      .MAX_ANCHORS(MaxAnchors)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_point_bits(req_point_bits),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid),
      .rsp_cluster_id(rsp_cluster_id),
      .rsp_new_cluster(rsp_new_cluster),
      .rsp_table_full(rsp_table_full),
      .rsp_point_index(rsp_point_index)
   );

   // Shadow copy of the clustering state.
   logic [VectorW-1:0] anchor_mem [MaxAnchors];
   int anchor_total;
   logic [hlc_pkg::IndexW-1:0] point_count;
   hlc_pkg::thr_type threshold;

   pending_op_type pending_ops[$];
   cluster_result_type expected_results[$];
   logic [hlc_pkg::PointW-1:0] point_history[$];

   logic req_taken = 1'b0;
   int burst_left = 4;
   int gap_left = 0;
   int mismatches = 0;
   int points_sent = 0;
   int thresholds_written = 0;
   int results_seen = 0;
   int new_seen = 0;
   int joined_seen = 0;
   int full_seen = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic cluster_result_type classify_point(
         input logic [hlc_pkg::PointW-1:0] point);
      cluster_result_type res;
      logic [VectorW-1:0] bits;
      bit claimed;
      int k;
      res = '0;
      bits = point[VectorW-1:0];
      claimed = 1'b0;
      for (k = 0; k < anchor_total && !claimed; k++) begin
         if ($countones(bits ^ anchor_mem[k]) < int'(threshold)) begin
            res.cluster_id = hlc_pkg::IdW'(k);
            claimed = 1'b1;
         end
      end
      if (!claimed) begin
         if (anchor_total < MaxAnchors) begin
            anchor_mem[anchor_total] = bits;
            res.cluster_id = hlc_pkg::IdW'(anchor_total);
            res.new_cluster = 1'b1;
            anchor_total++;
         end else begin
            res.table_full = 1'b1;
         end
      end
      res.point_index = point_count;
      point_count = point_count + hlc_pkg::IndexW'(1);
      return res;
   endfunction

   function automatic void add_point(input logic [hlc_pkg::PointW-1:0] value);
      pending_op_type op;
      op.kind = OP_POINT;
      op.value = value;
      pending_ops.insert(pending_ops.size(), op);
      point_history.insert(point_history.size(), value);
   endfunction

   function automatic void add_thresh(input int value);
      pending_op_type op;
      op.kind = OP_THRESH;
      op.value = hlc_pkg::PointW'(value);
      pending_ops.insert(pending_ops.size(), op);
   endfunction

   function automatic void add_drain();
      pending_op_type op;
      op.kind = OP_DRAIN;
      op.value = '0;
      pending_ops.insert(pending_ops.size(), op);
   endfunction

   // Flips a number of random bits of a point; a bit may be hit twice.
   function automatic logic [hlc_pkg::PointW-1:0] near_point(
         input logic [hlc_pkg::PointW-1:0] base, input int flips);
      logic [hlc_pkg::PointW-1:0] p;
      int i;
      p = base;
      for (i = 0; i < flips; i++) p[$urandom_range(0, hlc_pkg::PointW - 1)] ^= 1'b1;
      return p;
   endfunction

   function automatic logic [hlc_pkg::PointW-1:0] pick_history();
      return point_history[$urandom_range(0, point_history.size() - 1)];
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got, input logic [31:0] idx);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on point %0d: %s expected 0x%0h, got 0x%0h",
                     idx, name, want, got);
      end
   endtask

   // Monitor and predictor: results are checked before the new request is scored,
   // since a result always belongs to an earlier request.
   always @(posedge clock) begin
      cluster_result_type want;
      logic taken;
      taken = 1'b0;
      if (reset) begin
         anchor_total = 0;
         point_count = '0;
         threshold = hlc_pkg::ThrReset;
      end else begin
         if (rsp_valid) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result with nothing pending: id %0d index %0d",
                           rsp_cluster_id, rsp_point_index);
            end else begin
               want = expected_results.pop_front();
               check_field("cluster_id", 32'(want.cluster_id), 32'(rsp_cluster_id),
                           want.point_index);
               check_field("new_cluster", 32'(want.new_cluster), 32'(rsp_new_cluster),
                           want.point_index);
               check_field("table_full", 32'(want.table_full), 32'(rsp_table_full),
                           want.point_index);
               check_field("point_index", want.point_index, rsp_point_index,
                           want.point_index);
               if (want.table_full) full_seen++;
               else if (want.new_cluster) new_seen++;
               else joined_seen++;
            end
         end
         if (csr_wr_en) threshold = csr_wr_data;
         if (start && !busy) begin
            expected_results.insert(expected_results.size(), classify_point(req_point_bits));
            taken = 1'b1;
         end
      end
      req_taken <= taken;
   end

   // Request driver: bursts of requests separated by random gaps of varying length.
   always @(negedge clock) begin
      logic nxt_start;
      logic [hlc_pkg::PointW-1:0] nxt_point;
      logic nxt_wr;
      logic [hlc_pkg::ThrW-1:0] nxt_wr_data;
      bit idle;
      nxt_start = start;
      nxt_point = req_point_bits;
      nxt_wr = 1'b0;
      nxt_wr_data = csr_wr_data;
      if (!reset) begin
         if (start && req_taken) nxt_start = 1'b0;
         idle = !start && !busy && expected_results.size() == 0;
         if (!nxt_start) begin
            nxt_point = $urandom();
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_ops.size() > 0) begin
               case (pending_ops[0].kind)
                  OP_POINT: begin
                     nxt_start = 1'b1;
                     nxt_point = pending_ops[0].value;
                     void'(pending_ops.pop_front());
                     points_sent++;
                     burst_left--;
                     if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 7))
                           0, 1: gap_left = 0;
                           2: gap_left = $urandom_range(20, 300);
                           default: gap_left = $urandom_range(1, 12);
                        endcase
                     end
                  end
                  OP_THRESH: begin
                     if (idle) begin
                        nxt_wr = 1'b1;
                        nxt_wr_data = pending_ops[0].value[hlc_pkg::ThrW-1:0];
                        void'(pending_ops.pop_front());
                        thresholds_written++;
                     end
                  end
                  default: begin
                     if (idle) void'(pending_ops.pop_front());
                  end
               endcase
            end
         end
      end
      start <= nxt_start;
      req_point_bits <= nxt_point;
      csr_wr_en <= nxt_wr;
      csr_wr_data <= nxt_wr_data;
   end

   initial begin
      int phase;
      int i;
      int thr;
      int phase_thr [6];

      // Directed part, starting at the reset threshold of 4.
      add_point(32'h0000_0000);
      add_point(32'hFFFF_FFFF);
      add_point(32'h0000_0007);
      add_point(32'h0000_000F);
      add_point(32'hFFFF_FFF0);
      add_point(32'h7FFF_FFFF);
      add_point(32'h8000_0000);
      add_point(32'hAAAA_AAAA);
      add_point(32'h5555_5555);
      // With a zero threshold even an exact copy becomes a new anchor.
      add_thresh(0);
      add_point(32'h0000_0000);
      add_point(32'hAAAA_AAAA);
      // A threshold above the width lets the first anchor claim everything.
      add_thresh(63);
      add_point(32'h1234_5678);
      add_thresh(33);
      add_point(32'hFFFF_FFFF);
      add_thresh(32);
      add_point(32'hFFFF_FFFF);
      add_point(32'h0000_FFFF);
      add_thresh(1);
      add_point(32'h5555_5555);
      add_point(32'h5555_5554);

      // Random phases: mostly points close to earlier ones, some fully random.
      phase_thr = '{2, 4, 6, 9, 0, 33};
      phase_thr[4] = $urandom_range(1, 16);
      for (phase = 0; phase < 6; phase++) begin
         thr = phase_thr[phase];
         add_thresh(thr);
         for (i = 0; i < 110; i++) begin
            if (i == 55) add_drain();
            if ($urandom_range(0, 99) < 15) add_point($urandom());
            else add_point(near_point(pick_history(), $urandom_range(0, thr + 2)));
         end
      end

      // Fill the anchor table, then run past the end of it.
      add_thresh(0);
      for (i = 0; i < 260; i++) add_point($urandom());
      add_thresh(3);
      for (i = 0; i < 50; i++) begin
         if (i % 3 == 0) add_point($urandom());
         else add_point(near_point(pick_history(), $urandom_range(0, 3)));
      end
      add_thresh(10);
      for (i = 0; i < 30; i++) add_point(near_point(pick_history(), $urandom_range(0, 14)));
      add_thresh(0);
      for (i = 0; i < 10; i++) add_point(pick_history());
      add_thresh(4);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_ops.size() != 0 || start || busy || expected_results.size() != 0);
      repeat (TailCycles) @(posedge clock);

      $display("Sent %0d points over %0d threshold writes; %0d results checked.",
               points_sent, thresholds_written, results_seen);
      $display("Outcomes: %0d new anchors, %0d joined anchors, %0d dropped on a full table.",
               new_seen, joined_seen, full_seen);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout with %0d requests and %0d results outstanding",
               pending_ops.size(), expected_results.size());
      $display("TB_ERROR");
      $finish;
   end

endmodule

// File: hamming_leader_clustering_unit.f
rtl/hlc_pkg.sv
rtl/hlc_distance.sv
rtl/hamming_leader_clustering_unit.sv
dv/tb_hamming_leader_clustering_unit.sv
